[design/paged_framebuffer_rect_fill_macros.svh]
// Assertion macros for the paged framebuffer block.
// Both take a label and a property expression; clk and rst_n must be in scope.
`ifndef PAGED_FRAMEBUFFER_RECT_FILL_MACROS_SVH
`define PAGED_FRAMEBUFFER_RECT_FILL_MACROS_SVH

`ifndef SYNTHESIS

// check outside reset
`define PFBRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfbrf assertion failed");

// check that also holds while reset is applied
`define PFBRF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pfbrf assertion failed");

`else

`define PFBRF_ASSERT(lbl, prop)
`define PFBRF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[design/pfbrf_pkg.sv]
`default_nettype none

package pfbrf_pkg;

  // geometry of the store
  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = COLUMNS * PAGES;
  localparam int ADDR_W  = $clog2(DEPTH);

  // fixed field widths
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BYTE_W = 8;

  // internal column and row widths: hold the sum of start and span, and the edge
  localparam int CW = ((X_W + 1) > $clog2(COLUMNS + 1)) ? (X_W + 1) : $clog2(COLUMNS + 1);
  localparam int RW = ((Y_W + 1) > $clog2(ROWS + 1)) ? (Y_W + 1) : $clog2(ROWS + 1);
  localparam int PG_W = RW - 3;

  localparam logic [BYTE_W-1:0] FULL_MASK = 8'hFF;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_CLR  = 2'd1,
    OP_INV  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_step;
    logic walk_step;
    logic read_issue;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic in_read;
    logic in_on_screen;
    logic walk_last;
    logic out_free;
  } sts_t;

  // store address of one page byte
  function automatic logic [ADDR_W-1:0] byte_addr(logic [CW-1:0] col, logic [PG_W-1:0] page);
    return ADDR_W'(int'(col) * PAGES + int'(page));
  endfunction

  // pixel mask of one page inside the row range
  function automatic logic [BYTE_W-1:0] page_mask(logic [PG_W-1:0] page,
                                                  logic [PG_W-1:0] first,
                                                  logic [PG_W-1:0] last,
                                                  logic [2:0]      lo_bits,
                                                  logic [2:0]      hi_bits);
    logic [2:0] lo;
    logic [2:0] hi;
    lo = (page == first) ? lo_bits : 3'd0;
    hi = (page == last) ? hi_bits : 3'd7;
    return (FULL_MASK << lo) & (FULL_MASK >> (3'd7 - hi));
  endfunction

endpackage

`default_nettype wire

[design/pfbrf_if.sv]
`default_nettype none

// command channel
interface pfbrf_in_if;
  logic                           valid;
  logic                           ready;
  pfbrf_pkg::op_t                 op;
  logic [pfbrf_pkg::X_W-1:0]      x_start;
  logic [pfbrf_pkg::Y_W-1:0]      y_start;
  logic [pfbrf_pkg::X_W-1:0]      span_columns;
  logic [pfbrf_pkg::Y_W-1:0]      span_rows;

  modport source (output valid, output op, output x_start, output y_start,
                  output span_columns, output span_rows, input ready);
  modport sink   (input valid, input op, input x_start, input y_start,
                  input span_columns, input span_rows, output ready);
endinterface

// result channel
interface pfbrf_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfbrf_pkg::BYTE_W-1:0]   read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

`default_nettype wire

[design/pfbrf_ctrl.sv]
`default_nettype none

module pfbrf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pfbrf_pkg::sts_t sts,
  output pfbrf_pkg::cmd_t      cmd
);

  pfbrf_pkg::state_t state_r;
  pfbrf_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfbrf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfbrf_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = pfbrf_pkg::ST_IDLE;
      end
      pfbrf_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_read) state_nxt = pfbrf_pkg::ST_READ;
          else if (sts.in_on_screen) state_nxt = pfbrf_pkg::ST_WALK;
          else state_nxt = pfbrf_pkg::ST_FINISH;
        end
      end
      pfbrf_pkg::ST_WALK: begin
        if (sts.walk_last) state_nxt = pfbrf_pkg::ST_DRAIN;
      end
      pfbrf_pkg::ST_DRAIN: begin
        state_nxt = pfbrf_pkg::ST_FINISH;
      end
      pfbrf_pkg::ST_READ: begin
        state_nxt = pfbrf_pkg::ST_FINISH;
      end
      pfbrf_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = pfbrf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfbrf_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state_r == pfbrf_pkg::ST_IDLE);
    cmd.load       = (state_r == pfbrf_pkg::ST_IDLE) && in_valid;
    cmd.clear_step = (state_r == pfbrf_pkg::ST_CLEAR);
    cmd.walk_step  = (state_r == pfbrf_pkg::ST_WALK);
    cmd.read_issue = (state_r == pfbrf_pkg::ST_READ);
    cmd.push       = (state_r == pfbrf_pkg::ST_FINISH) && sts.out_free;
  end

endmodule

`default_nettype wire

[design/pfbrf_dp.sv]
`default_nettype none

module pfbrf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pfbrf_pkg::cmd_t               cmd,
  output pfbrf_pkg::sts_t                    sts,
  input  wire pfbrf_pkg::op_t                in_op,
  input  wire logic [pfbrf_pkg::X_W-1:0]     in_x_start,
  input  wire logic [pfbrf_pkg::Y_W-1:0]     in_y_start,
  input  wire logic [pfbrf_pkg::X_W-1:0]     in_span_columns,
  input  wire logic [pfbrf_pkg::Y_W-1:0]     in_span_rows,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pfbrf_pkg::BYTE_W-1:0]       out_read_byte
);

  localparam int CW     = pfbrf_pkg::CW;
  localparam int RW     = pfbrf_pkg::RW;
  localparam int PG_W   = pfbrf_pkg::PG_W;
  localparam int ADDR_W = pfbrf_pkg::ADDR_W;
  localparam int BYTE_W = pfbrf_pkg::BYTE_W;

  // frame store
  logic [BYTE_W-1:0] mem [pfbrf_pkg::DEPTH];

  // command registers
  pfbrf_pkg::op_t    op_r;
  logic [CW-1:0]     x0_r;
  logic [CW-1:0]     x1_r;
  logic [CW-1:0]     col_r;
  logic [PG_W-1:0]   page_r;
  logic [PG_W-1:0]   pfirst_r;
  logic [PG_W-1:0]   plast_r;
  logic [2:0]        ylo_r;
  logic [2:0]        yhi_r;
  logic              rd_ok_r;

  // read-modify-write pipeline
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [BYTE_W-1:0] wr_mask_r;
  logic [BYTE_W-1:0] rdata_r;

  // clearing pass and result register
  logic [ADDR_W-1:0] clr_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;

  // incoming command, widened
  logic [CW-1:0]     x0_in;
  logic [CW-1:0]     x1_sum;
  logic [CW-1:0]     x1_in;
  logic [RW-1:0]     y0_in;
  logic [RW-1:0]     y1_sum;
  logic [RW-1:0]     y1_in;
  logic [PG_W-1:0]   page_in;

  logic              rd_en;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] cur_mask;

  function automatic logic [BYTE_W-1:0] modify(pfbrf_pkg::op_t op, logic [BYTE_W-1:0] d,
                                               logic [BYTE_W-1:0] m);
    logic [BYTE_W-1:0] r;
    case (op)
      pfbrf_pkg::OP_SET: r = d | m;
      pfbrf_pkg::OP_CLR: r = d & ~m;
      default:           r = d ^ m;
    endcase
    return r;
  endfunction

  // clip the rectangle at the right and bottom edges
  always_comb begin
    x0_in   = CW'(in_x_start);
    x1_sum  = CW'(in_x_start) + CW'(in_span_columns);
    x1_in   = (x1_sum > CW'(pfbrf_pkg::COLUMNS - 1)) ? CW'(pfbrf_pkg::COLUMNS - 1) : x1_sum;
    y0_in   = RW'(in_y_start);
    y1_sum  = RW'(in_y_start) + RW'(in_span_rows);
    y1_in   = (y1_sum > RW'(pfbrf_pkg::ROWS - 1)) ? RW'(pfbrf_pkg::ROWS - 1) : y1_sum;
    page_in = y0_in[RW-1:3];
  end

  // status to the controller
  always_comb begin
    sts.clear_done   = (clr_r == ADDR_W'(pfbrf_pkg::DEPTH - 1));
    sts.in_read      = (in_op == pfbrf_pkg::OP_READ);
    sts.in_on_screen = (x0_in < CW'(pfbrf_pkg::COLUMNS)) && (y0_in < RW'(pfbrf_pkg::ROWS));
    sts.walk_last    = (col_r == x1_r) && (page_r == plast_r);
    sts.out_free     = !out_valid_r || out_ready;
  end

  // latch the command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      x0_r     <= x0_in;
      x1_r     <= x1_in;
      pfirst_r <= page_in;
      plast_r  <= y1_in[RW-1:3];
      ylo_r    <= y0_in[2:0];
      yhi_r    <= y1_in[2:0];
      rd_ok_r  <= (x0_in < CW'(pfbrf_pkg::COLUMNS)) && (page_in < PG_W'(pfbrf_pkg::PAGES));
    end
  end

  // walk columns within a page, then the next page
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r  <= x0_in;
      page_r <= page_in;
    end else if (cmd.walk_step) begin
      if (col_r == x1_r) begin
        col_r  <= x0_r;
        page_r <= page_r + PG_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  assign cur_mask = pfbrf_pkg::page_mask(page_r, pfirst_r, plast_r, ylo_r, yhi_r);

  // hold the pending write of each walked byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      wr_addr_r <= raddr;
      wr_mask_r <= cur_mask;
    end
  end

  // advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step && !sts.clear_done) begin
      clr_r <= clr_r + ADDR_W'(1);
    end
  end

  // memory port selection
  always_comb begin
    rd_en = cmd.walk_step || cmd.read_issue;
    raddr = pfbrf_pkg::byte_addr(col_r, page_r);
    we    = cmd.clear_step || wr_pend_r;
    waddr = cmd.clear_step ? clr_r : wr_addr_r;
    wdata = cmd.clear_step ? '0 : modify(op_r, rdata_r, wr_mask_r);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= ((op_r == pfbrf_pkg::OP_READ) && rd_ok_r) ? rdata_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_data_r;

endmodule

`default_nettype wire

[design/paged_framebuffer_rect_fill.sv]
// Paged monochrome framebuffer: COLUMNS columns by PAGES pages of 8-pixel bytes.
// Input channel in_if carries one command item: fill set, fill clear, invert
// a rectangle, or read one page byte. Output channel out_if returns exactly one
// item per command: the page byte for a read, zero for a drawing command.
// After reset the block runs a clearing pass over all COLUMNS*PAGES bytes of the
// store (1024 at the default size), one byte per cycle; in_if.ready stays low meanwhile.
// From accept to result valid, a read passes through the READ and FINISH states,
// an off-screen drawing command goes straight to FINISH, and a rectangle
// touching N page bytes passes through WALK, DRAIN and FINISH: the walk does one
// read-modify-write per byte per cycle through the single-port-pair store
// (N up to 1024), then the DRAIN state completes the last write.
// One command is in flight at a time; the next item can be accepted once the
// result has entered the output register.
// If out_if stalls, the result register holds its item and the block waits
// before handing over the next result; nothing is dropped.

`default_nettype none

`include "paged_framebuffer_rect_fill_macros.svh"

module paged_framebuffer_rect_fill (
  input  wire logic clk,
  input  wire logic rst_n,
  pfbrf_in_if.sink    in_if,
  pfbrf_out_if.source out_if
);

  pfbrf_pkg::cmd_t cmd;
  pfbrf_pkg::sts_t sts;

  pfbrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfbrf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_if.op),
    .in_x_start      (in_if.x_start),
    .in_y_start      (in_if.y_start),
    .in_span_columns (in_if.span_columns),
    .in_span_rows    (in_if.span_rows),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_read_byte   (out_if.read_byte)
  );

  // no item taken while the store is being cleared
  `PFBRF_ASSERT(a_no_accept_in_clear, cmd.clear_step |-> !in_if.ready)
  // a result is only pushed into a free output register
  `PFBRF_ASSERT(a_push_when_free, cmd.push |-> sts.out_free)
  // a pushed result is offered on the next cycle
  `PFBRF_ASSERT(a_push_shows, cmd.push |=> out_if.valid)
  // reset leaves both channels quiet
  `PFBRF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_if.valid && !in_if.ready))

endmodule

`default_nettype wire

[verif/pfbrf_frame_checker.sv]
`default_nettype none

// Watch both channels, keep a shadow copy of the frame store and compare each
// returned byte against the byte predicted at command accept time.
module pfbrf_frame_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  pfbrf_in_if       in_ch,
  pfbrf_out_if      out_ch,
  output int        fail_count,
  output int        pending_results
);
  import pfbrf_pkg::*;

  logic [BYTE_W-1:0] shadow_frame [DEPTH];
  logic [BYTE_W-1:0] expected_bytes [$];

  // Apply one command to the shadow store; return the byte the block must answer
  function automatic logic [BYTE_W-1:0] draw_and_predict(op_t op,
                                                         logic [X_W-1:0] x0,
                                                         logic [Y_W-1:0] y0,
                                                         logic [X_W-1:0] extra_cols,
                                                         logic [Y_W-1:0] extra_rows);
    int x_last;
    int y_last;
    int pg;
    int col;
    int row;
    int pix_row;
    int idx;
    logic [BYTE_W-1:0] mask;
    if (op == OP_READ) begin
      pg = int'(y0) / 8;
      if (int'(x0) >= COLUMNS || pg >= PAGES) return '0;
      return shadow_frame[int'(x0) * PAGES + pg];
    end
    // a start past the edge draws nothing
    if (int'(x0) >= COLUMNS || int'(y0) >= ROWS) return '0;
    // clip the far corner at the screen edge
    x_last = int'(x0) + int'(extra_cols);
    if (x_last > COLUMNS - 1) x_last = COLUMNS - 1;
    y_last = int'(y0) + int'(extra_rows);
    if (y_last > ROWS - 1) y_last = ROWS - 1;
    for (pg = int'(y0) / 8; pg <= y_last / 8; pg++) begin
      // build the mask row by row from the covered pixel rows
      mask = '0;
      for (row = 0; row < 8; row++) begin
        pix_row = pg * 8 + row;
        if (pix_row >= int'(y0) && pix_row <= y_last) mask[row] = 1'b1;
      end
      for (col = int'(x0); col <= x_last; col++) begin
        idx = col * PAGES + pg;
        case (op)
          OP_SET:  shadow_frame[idx] = shadow_frame[idx] | mask;
          OP_CLR:  shadow_frame[idx] = shadow_frame[idx] & ~mask;
          default: shadow_frame[idx] = shadow_frame[idx] ^ mask;
        endcase
      end
    end
    return '0;
  endfunction

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

  // Predict on command accept, compare on result accept
  always @(posedge clk) begin : track_items
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      expected_bytes.delete();
      pending_results <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_bytes.push_back(draw_and_predict(in_ch.op, in_ch.x_start, in_ch.y_start,
                                                  in_ch.span_columns, in_ch.span_rows));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("read_byte: item with no command outstanding, actual %02h",
                 out_ch.read_byte);
          fail_count = fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.read_byte !== want) begin
            $error("read_byte: expected %02h, actual %02h", want, out_ch.read_byte);
            fail_count = fail_count + 1;
          end
        end
      end
      pending_results <= expected_bytes.size();
    end
  end

endmodule

`default_nettype wire

[verif/paged_framebuffer_rect_fill_tb.sv]
`default_nettype none

module paged_framebuffer_rect_fill_tb;
  import pfbrf_pkg::*;

  // clearing pass plus a full-screen walk plus receiver stalls fit well inside
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 580;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   burst_left;
  int   idle_cycles;
  int   rx_cycle;
  int   rx_mode;
  int   rx_period;
  int   rx_duty;

  // last drawn rectangle, so reads can land on pixels just touched
  logic [X_W-1:0] last_x;
  logic [Y_W-1:0] last_y;
  logic [X_W-1:0] last_cols;
  logic [Y_W-1:0] last_rows;

  pfbrf_in_if  in_ch();
  pfbrf_out_if out_ch();

  paged_framebuffer_rect_fill dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  pfbrf_frame_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: switch between always ready, coin flip and periodic stall
  always @(negedge clk) begin
    if (rx_cycle % 150 == 0) begin
      rx_mode   = $urandom_range(0, 2);
      rx_period = $urandom_range(2, 12);
      rx_duty   = $urandom_range(1, rx_period);
    end
    case (rx_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 1) == 1);
      default: out_ch.ready = ((rx_cycle % rx_period) < rx_duty);
    endcase
    rx_cycle = rx_cycle + 1;
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one command item in the current burst; return at the falling edge after accept
  task automatic send_cmd(op_t op, logic [X_W-1:0] x0, logic [Y_W-1:0] y0,
                          logic [X_W-1:0] extra_cols, logic [Y_W-1:0] extra_rows);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.op           = op;
    in_ch.x_start      = x0;
    in_ch.y_start      = y0;
    in_ch.span_columns = extra_cols;
    in_ch.span_rows    = extra_rows;
    in_ch.valid        = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left = burst_left - 1;
    if (op != OP_READ) begin
      last_x    = x0;
      last_y    = y0;
      last_cols = extra_cols;
      last_rows = extra_rows;
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has returned
  task automatic drain_results();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Mostly small rectangles; a few full-range and edge-hugging ones
  task automatic send_random();
    op_t            op;
    logic [X_W-1:0] x0;
    logic [Y_W-1:0] y0;
    logic [X_W-1:0] extra_cols;
    logic [Y_W-1:0] extra_rows;
    int             size_pick;
    int             px;
    int             py;
    op         = op_t'($urandom_range(0, 3));
    size_pick  = $urandom_range(0, 19);
    x0         = X_W'($urandom_range(0, COLUMNS - 1));
    y0         = Y_W'($urandom_range(0, ROWS - 1));
    extra_cols = X_W'($urandom_range(0, 15));
    extra_rows = Y_W'($urandom_range(0, 23));
    if (size_pick == 0) begin
      extra_cols = X_W'($urandom_range(0, 127));
      extra_rows = Y_W'($urandom_range(0, 63));
    end else if (size_pick < 3) begin
      // push past the right and bottom edges
      x0         = X_W'($urandom_range(100, 127));
      y0         = Y_W'($urandom_range(40, 63));
      extra_cols = X_W'($urandom_range(0, 127));
      extra_rows = Y_W'($urandom_range(0, 63));
    end
    // reads mostly hit the rectangle just drawn
    if (op == OP_READ && $urandom_range(0, 9) < 6) begin
      px = int'(last_x) + $urandom_range(0, int'(last_cols));
      py = int'(last_y) + $urandom_range(0, int'(last_rows));
      if (px > COLUMNS - 1) px = COLUMNS - 1;
      if (py > ROWS - 1) py = ROWS - 1;
      x0 = X_W'(px);
      y0 = Y_W'(py);
    end
    send_cmd(op, x0, y0, extra_cols, extra_rows);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SET;
    in_ch.x_start      = '0;
    in_ch.y_start      = '0;
    in_ch.span_columns = '0;
    in_ch.span_rows    = '0;
    out_ch.ready       = 1'b0;
    burst_left         = 0;
    idle_cycles        = 0;
    rx_cycle           = 0;
    rx_mode            = 0;
    rx_period          = 2;
    rx_duty            = 1;
    last_x             = '0;
    last_y             = '0;
    last_cols          = '0;
    last_rows          = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // cleared store at the corners
    send_cmd(OP_READ, 7'd0,   6'd0,  7'd0,   6'd0);
    send_cmd(OP_READ, 7'd127, 6'd63, 7'd127, 6'd63);
    // single pixel at top-left and bottom-right
    send_cmd(OP_SET,  7'd0,   6'd0,  7'd0,   6'd0);
    send_cmd(OP_READ, 7'd0,   6'd7,  7'd0,   6'd0);
    send_cmd(OP_SET,  7'd127, 6'd63, 7'd0,   6'd0);
    send_cmd(OP_READ, 7'd127, 6'd56, 7'd0,   6'd0);
    // rectangle with a partial top page
    send_cmd(OP_INV,  7'd5,   6'd3,  7'd10,  6'd20);
    send_cmd(OP_READ, 7'd5,   6'd3,  7'd0,   6'd0);
    send_cmd(OP_READ, 7'd15,  6'd12, 7'd0,   6'd0);
    send_cmd(OP_READ, 7'd10,  6'd23, 7'd0,   6'd0);
    // rectangle within one page
    send_cmd(OP_SET,  7'd40,  6'd17, 7'd3,   6'd4);
    send_cmd(OP_READ, 7'd41,  6'd16, 7'd0,   6'd0);
    // clipped at the right and bottom edges
    send_cmd(OP_SET,  7'd120, 6'd60, 7'd127, 6'd63);
    send_cmd(OP_READ, 7'd127, 6'd63, 7'd0,   6'd0);
    send_cmd(OP_READ, 7'd0,   6'd63, 7'd0,   6'd0);
    // full screen: set, clear a band, invert all
    send_cmd(OP_SET,  7'd0,   6'd0,  7'd127, 6'd63);
    send_cmd(OP_READ, 7'd64,  6'd32, 7'd0,   6'd0);
    send_cmd(OP_CLR,  7'd0,   6'd9,  7'd127, 6'd45);
    send_cmd(OP_READ, 7'd100, 6'd9,  7'd0,   6'd0);
    send_cmd(OP_READ, 7'd100, 6'd55, 7'd0,   6'd0);
    send_cmd(OP_INV,  7'd0,   6'd0,  7'd127, 6'd63);
    send_cmd(OP_READ, 7'd0,   6'd8,  7'd0,   6'd0);
    send_cmd(OP_READ, 7'd127, 6'd40, 7'd0,   6'd0);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random();
      if (n % 97 == 96) drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
